>>> hw/rtl/opfb_pkg.sv
// ----------------------------------------------------------------------------
// opfb_pkg
// Shared types and constants of the OLED page-mode frame buffer.
// ----------------------------------------------------------------------------
package opfb_pkg;

  typedef enum logic [2:0] {
    ACT_PIXEL      = 3'd0,
    ACT_FILL       = 3'd1,
    ACT_CLEAR      = 3'd2,
    ACT_BLIT_START = 3'd3,
    ACT_BLIT_BYTE  = 3'd4,
    ACT_REFRESH    = 3'd5
  } act_t;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_CLEAR   = 7'b0000010,
    ST_FILL_RD = 7'b0000100,
    ST_FILL_WR = 7'b0001000,
    ST_BLIT_RD = 7'b0010000,
    ST_BLIT_WR = 7'b0100000,
    ST_REF_OUT = 7'b1000000
  } state_t;

  typedef enum logic [0:0] {
    REG_FIRST_PAGE = 1'b0,
    REG_LAST_PAGE  = 1'b1
  } reg_idx_t;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [8:0] BLIT_ROW_MAX  = 9'd511;
  localparam int         CMD_BYTES     = 3;

endpackage

>>> hw/rtl/oled_page_frame_buffer_core.sv
// ----------------------------------------------------------------------------
// oled_page_frame_buffer_core
// Monochrome page-mode frame buffer with pixel, fill, clear, blit and
// refresh byte stepping, built around one synchronous RAM.
// ----------------------------------------------------------------------------
// Flow: in_tready is high only in ST_IDLE, so a new item is taken only after
//   the last is through. Pixel, fill and blit bytes are each a RAM read then a
//   write; a blit byte covers up to 8 pixels; refresh gives one byte per item.
// Reset: synchronous; afterwards a clearing pass over all 2**ADDR_W bytes (1024
//   by default) zeroes the RAM while in_tready stays low.
module oled_page_frame_buffer_core #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // x_pos[7:0], y_pos[15:8], x_end[23:16], y_end[31:24], dot[32],
  // blit_width[40:33], byte_value[48:41], zero pad[55:49]
  input  logic [55:0] in_tdata,
  // action[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_byte[7:0]
  output logic [7:0]  out_tdata,
  // is_data[0]
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [2:0]  cfg_wr_data
);

  localparam int COL_W    = $clog2(COLUMNS);
  localparam int PG_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W   = PG_W + COL_W;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int ROWS     = 8 * PAGES;
  localparam int PAGE_LEN = COLUMNS + opfb_pkg::CMD_BYTES;
  localparam int POS_W    = $clog2(PAGE_LEN);

  localparam logic [PG_W-1:0]  PAGE_MAX = PG_W'(PAGES - 1);
  localparam logic [8:0]       COLS_9   = 9'(COLUMNS);
  localparam logic [8:0]       ROWS_9   = 9'(ROWS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAGE_LEN - 1);

  // input fields
  logic [7:0] x_pos, y_pos, x_end, y_end, blit_width, byte_value;
  logic       dot;
  opfb_pkg::act_t action;

  assign x_pos      = in_tdata[7:0];
  assign y_pos      = in_tdata[15:8];
  assign x_end      = in_tdata[23:16];
  assign y_end      = in_tdata[31:24];
  assign dot        = in_tdata[32];
  assign blit_width = in_tdata[40:33];
  assign byte_value = in_tdata[48:41];
  assign action     = opfb_pkg::act_t'(in_tuser);

  // registers
  opfb_pkg::state_t  state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [2:0]        cfg_first_r, cfg_first_nxt, cfg_last_r, cfg_last_nxt;

  logic [7:0]        fx_r, fx_nxt, fx_first_r, fx_first_nxt, fx_last_r, fx_last_nxt;
  logic [PG_W-1:0]   fg_r, fg_nxt, fg_first_r, fg_first_nxt, fg_last_r, fg_last_nxt;
  logic [2:0]        y_lo_r, y_lo_nxt, y_hi_r, y_hi_nxt;
  logic              dot_r, dot_nxt;

  logic [8:0]        bcol_r, bcol_nxt, brow_r, brow_nxt;
  logic [7:0]        borg_r, borg_nxt, bspan_r, bspan_nxt, bbits_r, bbits_nxt;
  logic [2:0]        bcnt_r, bcnt_nxt;

  logic [PG_W-1:0]   rpage_r, rpage_nxt;
  logic [POS_W-1:0]  rpos_r, rpos_nxt;
  logic              ref_cmd_r, ref_cmd_nxt, ref_last_r, ref_last_nxt;
  logic [7:0]        ref_byte_r, ref_byte_nxt;

  logic              out_valid_r, out_valid_nxt, out_isdata_r, out_isdata_nxt;
  logic              out_last_r, out_last_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;

  // frame RAM
  logic [7:0]        mem [DEPTH];
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata_r;

  always_ff @(posedge clk) begin
    if (ram_we) begin
      mem[ram_waddr] <= ram_wdata;
    end
    if (ram_re) begin
      ram_rdata_r <= mem[ram_raddr];
    end
  end

  // accept-time decode
  logic       accept;
  logic [7:0] xe_req, ye_req, x_last_eff, y_last_eff;
  logic       x_ok, y_ok;

  assign accept = in_tvalid && in_tready;
  assign xe_req = (action == opfb_pkg::ACT_PIXEL) ? x_pos : x_end;
  assign ye_req = (action == opfb_pkg::ACT_PIXEL) ? y_pos : y_end;
  assign x_last_eff = ({1'b0, xe_req} >= COLS_9) ? 8'(COLUMNS - 1) : xe_req;
  assign y_last_eff = ({1'b0, ye_req} >= ROWS_9) ? 8'(ROWS - 1) : ye_req;
  assign x_ok = (x_pos <= xe_req) && ({1'b0, x_pos} < COLS_9);
  assign y_ok = (y_pos <= ye_req) && ({1'b0, y_pos} < ROWS_9);

  // refresh cursor
  logic [PG_W-1:0]  first_pg, last_pg, last_raw, cur_page;
  logic [POS_W-1:0] cur_pos;
  logic [7:0]       cur_cmd;

  assign first_pg = (cfg_first_r > 3'(PAGES - 1)) ? PAGE_MAX : PG_W'(cfg_first_r);
  assign last_raw = (cfg_last_r > 3'(PAGES - 1)) ? PAGE_MAX : PG_W'(cfg_last_r);
  assign last_pg  = (last_raw < first_pg) ? first_pg : last_raw;

  always_comb begin
    if (rpage_r < first_pg || rpage_r > last_pg) begin
      cur_page = first_pg;
      cur_pos  = '0;
    end else begin
      cur_page = rpage_r;
      cur_pos  = rpos_r;
    end
    case (cur_pos)
      POS_W'(0): cur_cmd = opfb_pkg::CMD_PAGE_BASE + 8'(cur_page);
      POS_W'(1): cur_cmd = opfb_pkg::CMD_COL_LO;
      default:   cur_cmd = opfb_pkg::CMD_COL_HI;
    endcase
  end

  // fill mask of current page group
  logic [2:0]      fill_lo, fill_hi;
  logic [7:0]      fill_mask;
  logic [PG_W-1:0] fill_page, blit_page;
  logic            blit_on;
  logic [7:0]      blit_mask;
  logic [8:0]      bcol_inc, bwrap;

  assign fill_lo   = (fg_r == fg_first_r) ? y_lo_r : 3'd0;
  assign fill_hi   = (fg_r == fg_last_r) ? y_hi_r : 3'd7;
  assign fill_mask = (8'hFF >> fill_lo) & ~(8'hFF >> ({1'b0, fill_hi} + 4'd1));
  assign fill_page = PAGE_MAX - fg_r;

  assign blit_on   = (bcol_r < COLS_9) && (brow_r < ROWS_9);
  assign blit_page = PAGE_MAX - brow_r[PG_W+2:3];
  assign blit_mask = 8'h80 >> brow_r[2:0];
  assign bcol_inc  = bcol_r + 9'd1;
  assign bwrap     = {1'b0, borg_r} + {1'b0, bspan_r};

  assign in_tready = (state_r == opfb_pkg::ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cfg_first_nxt  = cfg_first_r;
    cfg_last_nxt   = cfg_last_r;
    fx_nxt         = fx_r;
    fx_first_nxt   = fx_first_r;
    fx_last_nxt    = fx_last_r;
    fg_nxt         = fg_r;
    fg_first_nxt   = fg_first_r;
    fg_last_nxt    = fg_last_r;
    y_lo_nxt       = y_lo_r;
    y_hi_nxt       = y_hi_r;
    dot_nxt        = dot_r;
    bcol_nxt       = bcol_r;
    brow_nxt       = brow_r;
    borg_nxt       = borg_r;
    bspan_nxt      = bspan_r;
    bbits_nxt      = bbits_r;
    bcnt_nxt       = bcnt_r;
    rpage_nxt      = rpage_r;
    rpos_nxt       = rpos_r;
    ref_cmd_nxt    = ref_cmd_r;
    ref_byte_nxt   = ref_byte_r;
    ref_last_nxt   = ref_last_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_isdata_nxt = out_isdata_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = {fill_page, fx_r[COL_W-1:0]};
    ram_raddr      = {fill_page, fx_r[COL_W-1:0]};
    ram_wdata      = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      case (opfb_pkg::reg_idx_t'(cfg_addr))
        opfb_pkg::REG_FIRST_PAGE: cfg_first_nxt = cfg_wr_data;
        opfb_pkg::REG_LAST_PAGE:  cfg_last_nxt  = cfg_wr_data;
        default: ;
      endcase
    end

    case (state_r)
      opfb_pkg::ST_IDLE: begin
        if (accept) begin
          case (action)
            opfb_pkg::ACT_PIXEL, opfb_pkg::ACT_FILL: begin
              fx_nxt       = x_pos;
              fx_first_nxt = x_pos;
              fx_last_nxt  = x_last_eff;
              fg_nxt       = y_pos[PG_W+2:3];
              fg_first_nxt = y_pos[PG_W+2:3];
              fg_last_nxt  = y_last_eff[PG_W+2:3];
              y_lo_nxt     = y_pos[2:0];
              y_hi_nxt     = y_last_eff[2:0];
              dot_nxt      = dot;
              if (x_ok && y_ok) begin
                state_nxt = opfb_pkg::ST_FILL_RD;
              end
            end
            opfb_pkg::ACT_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = opfb_pkg::ST_CLEAR;
            end
            opfb_pkg::ACT_BLIT_START: begin
              bcol_nxt  = {1'b0, x_pos};
              brow_nxt  = {1'b0, y_pos};
              borg_nxt  = x_pos;
              bspan_nxt = (blit_width == 8'd0) ? 8'd1 : blit_width;
            end
            opfb_pkg::ACT_BLIT_BYTE: begin
              bbits_nxt = byte_value;
              bcnt_nxt  = 3'd0;
              state_nxt = opfb_pkg::ST_BLIT_RD;
            end
            opfb_pkg::ACT_REFRESH: begin
              ref_cmd_nxt  = (cur_pos < POS_W'(opfb_pkg::CMD_BYTES));
              ref_byte_nxt = cur_cmd;
              ref_last_nxt = (cur_pos == POS_LAST) && (cur_page == last_pg);
              ram_re       = (cur_pos >= POS_W'(opfb_pkg::CMD_BYTES));
              ram_raddr    = {cur_page,
                              COL_W'(cur_pos - POS_W'(opfb_pkg::CMD_BYTES))};
              if (cur_pos == POS_LAST) begin
                rpos_nxt  = '0;
                rpage_nxt = (cur_page == last_pg) ? first_pg : cur_page + PG_W'(1);
              end else begin
                rpos_nxt  = cur_pos + POS_W'(1);
                rpage_nxt = cur_page;
              end
              state_nxt = opfb_pkg::ST_REF_OUT;
            end
            default: ;
          endcase
        end
      end
      opfb_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = 8'h00;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (&clr_addr_r) begin
          state_nxt = opfb_pkg::ST_IDLE;
        end
      end
      opfb_pkg::ST_FILL_RD: begin
        ram_re    = 1'b1;
        state_nxt = opfb_pkg::ST_FILL_WR;
      end
      opfb_pkg::ST_FILL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = dot_r ? (ram_rdata_r | fill_mask) : (ram_rdata_r & ~fill_mask);
        state_nxt = opfb_pkg::ST_FILL_RD;
        if (fx_r == fx_last_r) begin
          fx_nxt = fx_first_r;
          if (fg_r == fg_last_r) begin
            state_nxt = opfb_pkg::ST_IDLE;
          end else begin
            fg_nxt = fg_r + PG_W'(1);
          end
        end else begin
          fx_nxt = fx_r + 8'd1;
        end
      end
      opfb_pkg::ST_BLIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = {blit_page, bcol_r[COL_W-1:0]};
        state_nxt = opfb_pkg::ST_BLIT_WR;
      end
      opfb_pkg::ST_BLIT_WR: begin
        ram_we    = blit_on;
        ram_waddr = {blit_page, bcol_r[COL_W-1:0]};
        ram_wdata = bbits_r[7] ? (ram_rdata_r | blit_mask) : (ram_rdata_r & ~blit_mask);
        if (bcol_inc == bwrap) begin
          bcol_nxt  = {1'b0, borg_r};
          brow_nxt  = (brow_r == opfb_pkg::BLIT_ROW_MAX) ? brow_r : brow_r + 9'd1;
          state_nxt = opfb_pkg::ST_IDLE;
        end else begin
          bcol_nxt  = bcol_inc;
          bbits_nxt = {bbits_r[6:0], 1'b0};
          bcnt_nxt  = bcnt_r + 3'd1;
          state_nxt = (bcnt_r == 3'd7) ? opfb_pkg::ST_IDLE : opfb_pkg::ST_BLIT_RD;
        end
      end
      opfb_pkg::ST_REF_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = ref_cmd_r ? ref_byte_r : ram_rdata_r;
          out_isdata_nxt = !ref_cmd_r;
          out_last_nxt   = ref_last_r;
          state_nxt      = opfb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = opfb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= opfb_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      cfg_first_r <= 3'd0;
      cfg_last_r  <= 3'd7;
      bcol_r      <= 9'd0;
      brow_r      <= 9'd0;
      borg_r      <= 8'd0;
      bspan_r     <= 8'd1;
      bcnt_r      <= 3'd0;
      rpage_r     <= '0;
      rpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cfg_first_r <= cfg_first_nxt;
      cfg_last_r  <= cfg_last_nxt;
      bcol_r      <= bcol_nxt;
      brow_r      <= brow_nxt;
      borg_r      <= borg_nxt;
      bspan_r     <= bspan_nxt;
      bcnt_r      <= bcnt_nxt;
      rpage_r     <= rpage_nxt;
      rpos_r      <= rpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fx_r         <= fx_nxt;
    fx_first_r   <= fx_first_nxt;
    fx_last_r    <= fx_last_nxt;
    fg_r         <= fg_nxt;
    fg_first_r   <= fg_first_nxt;
    fg_last_r    <= fg_last_nxt;
    y_lo_r       <= y_lo_nxt;
    y_hi_r       <= y_hi_nxt;
    dot_r        <= dot_nxt;
    bbits_r      <= bbits_nxt;
    ref_cmd_r    <= ref_cmd_nxt;
    ref_byte_r   <= ref_byte_nxt;
    ref_last_r   <= ref_last_nxt;
    out_byte_r   <= out_byte_nxt;
    out_isdata_r <= out_isdata_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_isdata_r;
  assign out_tlast  = out_last_r;

endmodule

>>> hw/rtl/opfb_checker.sv
// ----------------------------------------------------------------------------
// opfb_checker
// Port-level checks of the frame buffer core, bound into oled_page_frame_buffer_core.
// ----------------------------------------------------------------------------
module opfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("frame end flagged on a command beat");

  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata == 8'h00 || out_tdata == 8'h10
      || out_tdata[7:4] == 4'hB))
    else $error("unexpected command byte");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_tready && !out_tvalid)
    else $error("input open or result present during reset clear");

endmodule

bind oled_page_frame_buffer_core opfb_checker u_opfb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
